[hdl/iwt_pkg.sv]
// Shared constants, types and helpers for the integer-to-word-token block.
package iwt_pkg;

    localparam int ValueW     = 31;
    localparam int CodeW      = 5;
    localparam int DigitW     = 4;
    localparam int Digits     = 10;
    localparam int Groups     = 4;
    localparam int GroupSlots = 5;
    localparam int SlotZero   = Groups * GroupSlots;
    localparam int Slots      = SlotZero + 1;
    localparam int ShiftW     = 32;
    localparam int StepBits   = 4;
    localparam int Steps      = ShiftW / StepBits;
    localparam int StepCntW   = $clog2(Steps);
    localparam int QueueDepth = 2;

    localparam int PhaseHundDigit = 0;
    localparam int PhaseHundred   = 1;
    localparam int PhaseTens      = 2;
    localparam int PhaseOnes      = 3;
    localparam int PhaseScale     = 4;

    localparam logic [CodeW-1:0] CodeZero     = 5'd0;
    localparam logic [CodeW-1:0] CodeTeenBase = 5'd10;
    localparam logic [CodeW-1:0] CodeTensBase = 5'd18;
    localparam logic [CodeW-1:0] CodeHundred  = 5'd28;
    localparam logic [CodeW-1:0] CodeThousand = 5'd29;
    localparam logic [CodeW-1:0] CodeMillion  = 5'd30;
    localparam logic [CodeW-1:0] CodeBillion  = 5'd31;

    typedef logic [Digits-1:0][DigitW-1:0] digits_t;

    typedef struct packed {
        digits_t          digit;
        logic [Slots-1:0] mask;
    } iwt_rec_t;

    function automatic logic [CodeW-1:0] scale_code(input int grp);
        logic [CodeW-1:0] code;
        case (grp)
            0:       code = CodeBillion;
            1:       code = CodeMillion;
            2:       code = CodeThousand;
            default: code = CodeZero;
        endcase
        return code;
    endfunction

endpackage

[hdl/integer_to_word_tokens_top.sv]
// Top level of the integer-to-word-token block.
// Spells a 31-bit unsigned number as American English word tokens, one token per output
// transaction, with last_word set on the final token. The front end converts each number to
// decimal in a shift-and-add-3 unit that handles four bits a cycle, and takes no new number
// until the last one is converted and the queue has room for it; the back end emits one token
// per cycle while the output is not stalled, between 1 and 16 tokens per number. A queue of
// QUEUE_DEPTH converted numbers sits between them.
module integer_to_word_tokens_top #(
    parameter int QUEUE_DEPTH = iwt_pkg::QueueDepth
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [iwt_pkg::ValueW-1:0]  value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [iwt_pkg::CodeW-1:0]   word_code,
    output logic                        last_word
);

    logic              push_valid;
    logic              push_full;
    iwt_pkg::iwt_rec_t push_data;
    logic              pop_valid;
    logic              pop;
    iwt_pkg::iwt_rec_t pop_data;

    iwt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_data  (push_data)
    );

    iwt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    iwt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word_code (word_code),
        .last_word (last_word)
    );

endmodule

[hdl/iwt_front.sv]
// Front end: takes a number, converts it to decimal digits and marks which tokens it emits.
module iwt_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [iwt_pkg::ValueW-1:0]   value,
    output logic                         push_valid,
    input  logic                         push_full,
    output iwt_pkg::iwt_rec_t            push_data
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [iwt_pkg::StepCntW-1:0]      cnt_reg, cnt_next;
    logic [iwt_pkg::ShiftW-1:0]        shift_reg, shift_next;
    iwt_pkg::digits_t                  bcd_reg, bcd_next;
    logic [iwt_pkg::ShiftW-1:0]        shift_step;
    iwt_pkg::digits_t                  bcd_step;
    logic                              accept;
    logic                              push;
    logic [iwt_pkg::Digits+1:0][iwt_pkg::DigitW-1:0] dx;

    assign in_stall   = busy_reg || (done_reg && push_full);
    assign accept     = in_valid && !in_stall;
    assign push_valid = done_reg;
    assign push       = done_reg && !push_full;

    always_comb
    begin
        bcd_step   = bcd_reg;
        shift_step = shift_reg;
        for (int b = 0; b < iwt_pkg::StepBits; b++)
        begin
            for (int k = 0; k < iwt_pkg::Digits; k++)
            begin
                if (bcd_step[k] >= 4'd5)
                begin
                    bcd_step[k] = bcd_step[k] + 4'd3;
                end
            end
            bcd_step   = {bcd_step[iwt_pkg::Digits-1][iwt_pkg::DigitW-2:0],
                          bcd_step[iwt_pkg::Digits-2:0], shift_step[iwt_pkg::ShiftW-1]};
            shift_step = {shift_step[iwt_pkg::ShiftW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (push)
        begin
            done_next = 1'b0;
        end
        if (accept)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = {{(iwt_pkg::ShiftW - iwt_pkg::ValueW){1'b0}}, value};
            bcd_next   = '0;
        end
        else if (busy_reg)
        begin
            shift_next = shift_step;
            bcd_next   = bcd_step;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == iwt_pkg::StepCntW'(iwt_pkg::Steps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign dx = {{(2 * iwt_pkg::DigitW){1'b0}}, bcd_reg};
    assign push_data.digit = bcd_reg;
    assign push_data.mask[iwt_pkg::SlotZero] = (bcd_reg == '0);

    for (genvar g = 0; g < iwt_pkg::Groups; g++)
    begin : g_grp
        localparam int OnesIdx = 3 * (iwt_pkg::Groups - 1 - g);
        localparam int Base    = g * iwt_pkg::GroupSlots;
        logic [iwt_pkg::DigitW-1:0] h, t, o;
        assign o = dx[OnesIdx];
        assign t = dx[OnesIdx + 1];
        assign h = dx[OnesIdx + 2];
        assign push_data.mask[Base + iwt_pkg::PhaseHundDigit] = (h != '0);
        assign push_data.mask[Base + iwt_pkg::PhaseHundred]   = (h != '0);
        assign push_data.mask[Base + iwt_pkg::PhaseTens]      = (t >= 4'd2);
        assign push_data.mask[Base + iwt_pkg::PhaseOnes]      = (t == 4'd1) || (o != '0);
        if (g < iwt_pkg::Groups - 1)
        begin : g_scale
            assign push_data.mask[Base + iwt_pkg::PhaseScale] =
                (h != '0) || (t != '0) || (o != '0);
        end
        else
        begin : g_noscale
            assign push_data.mask[Base + iwt_pkg::PhaseScale] = 1'b0;
        end
    end

endmodule

[hdl/iwt_queue.sv]
// Small FIFO that carries converted numbers from the front end to the token sequencer.
module iwt_queue #(
    parameter int DEPTH = iwt_pkg::QueueDepth
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_full,
    input  iwt_pkg::iwt_rec_t push_data,
    output logic              pop_valid,
    input  logic              pop,
    output iwt_pkg::iwt_rec_t pop_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    iwt_pkg::iwt_rec_t mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_full = (count_reg == CntW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push_valid && !push_full;
    assign do_pop    = pop && pop_valid;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/iwt_back.sv]
// Back end: walks the token mask of each number and drives one token per transaction.
module iwt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop,
    input  iwt_pkg::iwt_rec_t           pop_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [iwt_pkg::CodeW-1:0]   word_code,
    output logic                        last_word
);

    logic                            work_valid_reg, work_valid_next;
    iwt_pkg::iwt_rec_t               work_reg, work_next;
    logic                            out_valid_reg, out_valid_next;
    logic [iwt_pkg::CodeW-1:0]       code_reg, code_next;
    logic                            last_reg, last_next;
    logic [iwt_pkg::Slots-1:0]       low_bit;
    logic                            is_last;
    logic                            tok_load;
    logic                            work_done;
    logic [iwt_pkg::CodeW-1:0]       tok [iwt_pkg::Slots];
    logic [iwt_pkg::CodeW-1:0]       cur_code;
    logic [iwt_pkg::Digits+1:0][iwt_pkg::DigitW-1:0] dx;

    assign dx = {{(2 * iwt_pkg::DigitW){1'b0}}, work_reg.digit};

    for (genvar g = 0; g < iwt_pkg::Groups; g++)
    begin : g_grp
        localparam int OnesIdx = 3 * (iwt_pkg::Groups - 1 - g);
        localparam int Base    = g * iwt_pkg::GroupSlots;
        logic [iwt_pkg::DigitW-1:0] h, t, o;
        assign o = dx[OnesIdx];
        assign t = dx[OnesIdx + 1];
        assign h = dx[OnesIdx + 2];
        assign tok[Base + iwt_pkg::PhaseHundDigit] = {1'b0, h};
        assign tok[Base + iwt_pkg::PhaseHundred]   = iwt_pkg::CodeHundred;
        assign tok[Base + iwt_pkg::PhaseTens]      = iwt_pkg::CodeTensBase + {1'b0, t};
        assign tok[Base + iwt_pkg::PhaseOnes]      = (t == 4'd1) ?
                                                     iwt_pkg::CodeTeenBase + {1'b0, o} :
                                                     {1'b0, o};
        assign tok[Base + iwt_pkg::PhaseScale]     = iwt_pkg::scale_code(g);
    end
    assign tok[iwt_pkg::SlotZero] = iwt_pkg::CodeZero;

    always_comb
    begin
        cur_code = iwt_pkg::CodeZero;
        for (int s = iwt_pkg::Slots - 1; s >= 0; s--)
        begin
            if (work_reg.mask[s])
            begin
                cur_code = tok[s];
            end
        end
    end

    assign low_bit   = work_reg.mask & (~work_reg.mask + 1'b1);
    assign is_last   = ((work_reg.mask & (work_reg.mask - 1'b1)) == '0);
    assign tok_load  = work_valid_reg && (!out_valid_reg || !out_stall);
    assign work_done = tok_load && is_last;
    assign pop       = pop_valid && (!work_valid_reg || work_done);

    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_next       = work_reg;
        if (pop)
        begin
            work_valid_next = 1'b1;
            work_next       = pop_data;
        end
        else if (work_done)
        begin
            work_valid_next = 1'b0;
        end
        else if (tok_load)
        begin
            work_next.mask = work_reg.mask & ~low_bit;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        if (tok_load)
        begin
            out_valid_next = 1'b1;
            code_next      = cur_code;
            last_next      = is_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign word_code = code_reg;
    assign last_word = last_reg;

endmodule
